[design/mch_pkg.sv]
// shared types, constants and lookup tables for the compass heading block
// no dependencies
package mch_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int SCALE_FRAC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_LAYOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 3'd7;

  // chip layout codes
  localparam logic [1:0] LAYOUT_BE_XZY = 2'd0;
  localparam logic [1:0] LAYOUT_LE_XYZ = 2'd1;
  localparam logic [1:0] LAYOUT_NONE   = 2'd2;

  localparam logic [15:0] OVF_MARK   = 16'hF000;
  localparam logic [15:0] SCALE_ONE  = 16'd4096;

  // cordic datapath widths: 16-bit input scaled by 256, plus gain headroom
  localparam int XW = 27;
  localparam int AW = 27;
  localparam int HW = 19;

  localparam logic signed [AW-1:0] HALF_TURN_DEG16 = AW'(180 * 65536);
  localparam logic signed [AW-1:0] ROUND_BIAS      = AW'(256);
  localparam logic signed [HW-1:0] FULL_TURN       = HW'(46080);

  typedef struct packed {
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [7:0] data_byte2;
    logic [7:0] data_byte3;
    logic [7:0] data_byte4;
    logic [7:0] data_byte5;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               sample_rejected;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctrl_t;

  // atan(2^-i) in 2^-16 degree units
  function automatic logic [21:0] atan_deg16(input logic [4:0] i);
    logic [21:0] t;
    case (i)
      5'd0:    t = 22'd2949120;
      5'd1:    t = 22'd1740967;
      5'd2:    t = 22'd919879;
      5'd3:    t = 22'd466945;
      5'd4:    t = 22'd234379;
      5'd5:    t = 22'd117304;
      5'd6:    t = 22'd58666;
      5'd7:    t = 22'd29335;
      5'd8:    t = 22'd14668;
      5'd9:    t = 22'd7334;
      5'd10:   t = 22'd3667;
      5'd11:   t = 22'd1833;
      5'd12:   t = 22'd917;
      5'd13:   t = 22'd458;
      5'd14:   t = 22'd229;
      5'd15:   t = 22'd115;
      5'd16:   t = 22'd57;
      5'd17:   t = 22'd29;
      5'd18:   t = 22'd14;
      5'd19:   t = 22'd7;
      5'd20:   t = 22'd4;
      5'd21:   t = 22'd2;
      5'd22:   t = 22'd1;
      default: t = 22'd0;
    endcase
    return t;
  endfunction

endpackage

[design/mch_calib.sv]
// offset subtract and scale multiply, shared by the three axes
// product registered, truncation toward zero and saturation after the register
// depends on mch_pkg
module mch_calib #(
  parameter int SCALE_FRAC_BITS = mch_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [15:0] raw,
  input  logic signed [15:0] offset,
  input  logic [15:0]        scale,
  output logic signed [15:0] cal
);
  import mch_pkg::*;

  localparam int PW = 34;
  localparam logic signed [PW-1:0] TRUNC_BIAS = PW'((64'd1 << SCALE_FRAC_BITS) - 64'd1);
  localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(32768);

  logic signed [16:0]   diff;
  logic signed [16:0]   scl_ext;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] biased;
  logic signed [PW-1:0] quot;

  assign diff     = 17'(raw) - 17'(offset);
  assign scl_ext  = $signed({1'b0, scale});
  assign prod_nxt = PW'(diff) * PW'(scl_ext);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // negative values get the bias so the shift rounds toward zero
  assign biased = prod_r[PW-1] ? (prod_r + TRUNC_BIAS) : prod_r;
  assign quot   = biased >>> SCALE_FRAC_BITS;

  always_comb begin
    if (quot > SAT_HI) begin
      cal = 16'sh7FFF;
    end else if (quot < SAT_LO) begin
      cal = -16'sh8000;
    end else begin
      cal = quot[15:0];
    end
  end

endmodule

[design/mch_cordic.sv]
// vectoring cordic, one shift-add rotation per cycle while step is high
// gives the angle of (x, y) in 2^-16 degree units; depends on mch_pkg
module mch_cordic #(
  parameter int CORDIC_STEPS = mch_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  mch_pkg::cordic_ctrl_t        ctrl,
  input  logic signed [15:0]           x_in,
  input  logic signed [15:0]           y_in,
  output logic                         last_step,
  output logic signed [mch_pkg::AW-1:0] angle
);
  import mch_pkg::*;

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_IDX = STEP_W'(CORDIC_STEPS - 1);

  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [AW-1:0] a_r, a_nxt;
  logic [STEP_W-1:0]    idx_r, idx_nxt;
  logic                 zero_r, zero_nxt;
  logic signed [XW-1:0] x_ld, y_ld, xs, ys;
  logic signed [AW-1:0] t_ext;

  assign x_ld  = {{(XW-24){x_in[15]}}, x_in, 8'h00};
  assign y_ld  = {{(XW-24){y_in[15]}}, y_in, 8'h00};
  assign xs    = x_r >>> idx_r;
  assign ys    = y_r >>> idx_r;
  assign t_ext = AW'(atan_deg16(5'(idx_r)));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    a_nxt    = a_r;
    idx_nxt  = idx_r;
    zero_nxt = zero_r;
    if (ctrl.load) begin
      idx_nxt  = '0;
      zero_nxt = (x_in == 16'sd0) && (y_in == 16'sd0);
      if (x_in[15]) begin
        x_nxt = -x_ld;
        y_nxt = -y_ld;
        a_nxt = HALF_TURN_DEG16;
      end else begin
        x_nxt = x_ld;
        y_nxt = y_ld;
        a_nxt = '0;
      end
    end else if (ctrl.step) begin
      idx_nxt = idx_r + STEP_W'(1);
      if (!y_r[XW-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        a_nxt = a_r + t_ext;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        a_nxt = a_r - t_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    a_r    <= a_nxt;
    idx_r  <= idx_nxt;
    zero_r <= zero_nxt;
  end

  assign last_step = ctrl.step && (idx_r == LAST_IDX);
  // a zero vector has no direction, report angle zero
  assign angle     = zero_r ? '0 : a_r;

endmodule

[design/magnetometer_compass_heading.sv]
// compass heading top level: config registers, calibrated field store, sequencer
// uses mch_pkg, mch_calib and mch_cordic
//
//  channel | ports                         | payload
//  in      | in_valid / in_ready           | in_data (six sensor bytes)
//  out     | out_valid / out_ready         | out_data (heading, field x/y/z, reject)
//  cfg     | cfg_we, cfg_addr, cfg_wdata   | one register write per cycle
//
// a kept sample: calibration of the three axes on the shared multiplier (S_CAL),
// a load (S_LOAD), CORDIC_STEPS rotations on the shared cordic (S_ITER), then
// rounding (S_RND) and wrap (S_WRAP); a rejected sample skips calibration, and
// a new beat is taken only once the previous one has left the wrap stage
// in_ready is high only while idle; the wrap stage stalls while the output is full
// synchronous active-low reset: config defaults, control and stored fields cleared
module magnetometer_compass_heading #(
  parameter int CORDIC_STEPS    = mch_pkg::CORDIC_STEPS_DEF,
  parameter int SCALE_FRAC_BITS = mch_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mch_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mch_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [mch_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mch_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mch_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CAL  = 6'b000010,
    S_LOAD = 6'b000100,
    S_ITER = 6'b001000,
    S_RND  = 6'b010000,
    S_WRAP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [1:0]         layout_r;
  logic signed [15:0] off_x_r, off_y_r, off_z_r;
  logic [15:0]        scl_x_r, scl_y_r, scl_z_r;
  logic signed [15:0] decl_r;

  // stored calibrated field
  logic signed [15:0] last_x_r, last_y_r, last_z_r;

  in_beat_t           beat_r;
  logic               rej_r;
  logic [1:0]         axis_r, axis_nxt;
  logic signed [HW-1:0] sum_r;
  logic               out_valid_r;
  out_beat_t          out_r;

  logic               accept;
  logic               rej_now;
  logic [15:0]        raw_be_x, raw_be_y, raw_be_z;
  logic signed [15:0] raw_x, raw_y, raw_z;
  logic signed [15:0] mul_raw, mul_off, cal;
  logic [15:0]        mul_scl;
  cordic_ctrl_t       cctrl;
  logic               cordic_last;
  logic signed [AW-1:0] angle;
  logic signed [AW-1:0] angle_rnd;
  logic signed [HW-1:0] sum_nxt;
  logic signed [HW-1:0] heading_w;
  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // big-endian X,Z,Y layout, used for the overflow check on the incoming beat
  assign raw_be_x = {in_data.data_byte0, in_data.data_byte1};
  assign raw_be_z = {in_data.data_byte2, in_data.data_byte3};
  assign raw_be_y = {in_data.data_byte4, in_data.data_byte5};

  always_comb begin
    rej_now = 1'b1;
    case (layout_r)
      LAYOUT_BE_XZY: rej_now = (raw_be_x == OVF_MARK) || (raw_be_y == OVF_MARK)
                               || (raw_be_z == OVF_MARK);
      LAYOUT_LE_XYZ: rej_now = 1'b0;
      default:       rej_now = 1'b1;
    endcase
  end

  always_comb begin
    if (layout_r == LAYOUT_BE_XZY) begin
      raw_x = {beat_r.data_byte0, beat_r.data_byte1};
      raw_z = {beat_r.data_byte2, beat_r.data_byte3};
      raw_y = {beat_r.data_byte4, beat_r.data_byte5};
    end else begin
      raw_x = {beat_r.data_byte1, beat_r.data_byte0};
      raw_y = {beat_r.data_byte3, beat_r.data_byte2};
      raw_z = {beat_r.data_byte5, beat_r.data_byte4};
    end
  end

  // axis fed to the multiplier; its result is stored in the following cycle
  always_comb begin
    case (axis_r)
      2'd0: begin
        mul_raw = raw_x;
        mul_off = off_x_r;
        mul_scl = scl_x_r;
      end
      2'd1: begin
        mul_raw = raw_y;
        mul_off = off_y_r;
        mul_scl = scl_y_r;
      end
      default: begin
        mul_raw = raw_z;
        mul_off = off_z_r;
        mul_scl = scl_z_r;
      end
    endcase
  end

  mch_calib #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_calib (
    .clk    (clk),
    .raw    (mul_raw),
    .offset (mul_off),
    .scale  (mul_scl),
    .cal    (cal)
  );

  assign cctrl.load = (state_r == S_LOAD);
  assign cctrl.step = (state_r == S_ITER);

  mch_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .ctrl      (cctrl),
    .x_in      (last_x_r),
    .y_in      (last_y_r),
    .last_step (cordic_last),
    .angle     (angle)
  );

  // round to 1/128 degree and add declination
  assign angle_rnd = (angle + ROUND_BIAS) >>> 9;
  assign sum_nxt   = HW'(angle_rnd) + HW'(decl_r);

  // the sum stays within one turn of the target range
  always_comb begin
    if (sum_r[HW-1]) begin
      heading_w = sum_r + FULL_TURN;
    end else if (sum_r >= FULL_TURN) begin
      heading_w = sum_r - FULL_TURN;
    end else begin
      heading_w = sum_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        axis_nxt = 2'd0;
        if (accept) begin
          state_nxt = rej_now ? S_LOAD : S_CAL;
        end
      end
      S_CAL: begin
        axis_nxt = axis_r + 2'd1;
        if (axis_r == 2'd3) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_ITER;
      S_ITER: begin
        if (cordic_last) begin
          state_nxt = S_RND;
        end
      end
      S_RND: state_nxt = S_WRAP;
      S_WRAP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 2'd0;
      layout_r    <= LAYOUT_NONE;
      off_x_r     <= '0;
      off_y_r     <= '0;
      off_z_r     <= '0;
      scl_x_r     <= SCALE_ONE;
      scl_y_r     <= SCALE_ONE;
      scl_z_r     <= SCALE_ONE;
      decl_r      <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CHIP_LAYOUT: layout_r <= cfg_wdata[1:0];
          REG_OFFSET_X:    off_x_r  <= cfg_wdata;
          REG_OFFSET_Y:    off_y_r  <= cfg_wdata;
          REG_OFFSET_Z:    off_z_r  <= cfg_wdata;
          REG_SCALE_X:     scl_x_r  <= cfg_wdata;
          REG_SCALE_Y:     scl_y_r  <= cfg_wdata;
          REG_SCALE_Z:     scl_z_r  <= cfg_wdata;
          REG_DECLINATION: decl_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        rej_r <= rej_now;
      end
      if (state_r == S_CAL) begin
        case (axis_r)
          2'd1:    last_x_r <= cal;
          2'd2:    last_y_r <= cal;
          2'd3:    last_z_r <= cal;
          default: ;
        endcase
      end
      if (state_r == S_WRAP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= in_data;
    end
    if (state_r == S_RND) begin
      sum_r <= sum_nxt;
    end
    if (state_r == S_WRAP && out_free) begin
      out_r.heading         <= heading_w[15:0];
      out_r.field_x         <= last_x_r;
      out_r.field_y         <= last_y_r;
      out_r.field_z         <= last_z_r;
      out_r.sample_rejected <= rej_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[dv/magnetometer_compass_heading_tb.sv]
// testbench for magnetometer_compass_heading: directed and random sensor beats,
// checked against an in-bench heading predictor. depends on mch_pkg and the block
module magnetometer_compass_heading_tb;

  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         FULL_CIRCLE    = 46080;
  localparam logic [1:0] LAYOUT_SPARE   = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  mch_pkg::in_beat_t                in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  mch_pkg::out_beat_t               out_data;
  logic                             cfg_we = 1'b0;
  logic [mch_pkg::CFG_IDX_W-1:0]    cfg_addr = '0;
  logic [mch_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  magnetometer_compass_heading dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // register values seen by the block, and the plan for the next write pass
  logic [15:0] cfg_shadow [8];
  logic [15:0] reg_plan [8];

  // calibrated field store of the predictor
  logic signed [15:0] fld_x, fld_y, fld_z;

  longint atan_steps [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  mch_pkg::out_beat_t heading_q [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int err_count = 0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int settings_applied = 0;
  int rejects_seen = 0;

  function automatic logic signed [15:0] calibrate(logic signed [15:0] raw,
                                                   logic signed [15:0] off,
                                                   logic [15:0] scl);
    longint d;
    longint p;
    d = longint'(raw) - longint'(off);
    p = d * longint'(scl);
    p = p / 4096;  // truncates toward zero
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return 16'(p);
  endfunction

  // vectoring cordic, angle in 2^-16 degree
  function automatic longint cordic_angle(longint xi, longint yi);
    longint x, y, a, xs, ys;
    int i;
    if (xi == 0 && yi == 0) return 0;
    x = xi * 256;
    y = yi * 256;
    a = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = 180 * 65536;
    end
    for (i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        a = a + atan_steps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        a = a - atan_steps[i];
      end
    end
    return a;
  endfunction

  function automatic mch_pkg::out_beat_t predict_heading(mch_pkg::in_beat_t b);
    mch_pkg::out_beat_t r;
    logic signed [15:0] rx, ry, rz;
    logic rej;
    longint h;
    rx = '0;
    ry = '0;
    rz = '0;
    rej = 1'b0;
    case (cfg_shadow[mch_pkg::REG_CHIP_LAYOUT][1:0])
      mch_pkg::LAYOUT_BE_XZY: begin
        rx = {b.data_byte0, b.data_byte1};
        rz = {b.data_byte2, b.data_byte3};
        ry = {b.data_byte4, b.data_byte5};
        rej = (rx == mch_pkg::OVF_MARK) || (ry == mch_pkg::OVF_MARK) ||
              (rz == mch_pkg::OVF_MARK);
      end
      mch_pkg::LAYOUT_LE_XYZ: begin
        rx = {b.data_byte1, b.data_byte0};
        ry = {b.data_byte3, b.data_byte2};
        rz = {b.data_byte5, b.data_byte4};
      end
      default: rej = 1'b1;
    endcase
    if (!rej) begin
      fld_x = calibrate(rx, cfg_shadow[mch_pkg::REG_OFFSET_X], cfg_shadow[mch_pkg::REG_SCALE_X]);
      fld_y = calibrate(ry, cfg_shadow[mch_pkg::REG_OFFSET_Y], cfg_shadow[mch_pkg::REG_SCALE_Y]);
      fld_z = calibrate(rz, cfg_shadow[mch_pkg::REG_OFFSET_Z], cfg_shadow[mch_pkg::REG_SCALE_Z]);
    end
    h = ((cordic_angle(longint'(fld_x), longint'(fld_y)) + 256) >>> 9) +
        longint'($signed(cfg_shadow[mch_pkg::REG_DECLINATION]));
    h = h % FULL_CIRCLE;
    if (h < 0) h = h + FULL_CIRCLE;
    r.heading = 16'(h);
    r.field_x = fld_x;
    r.field_y = fld_y;
    r.field_z = fld_z;
    r.sample_rejected = rej;
    return r;
  endfunction

  // place three raw axes into the byte order of the current layout
  function automatic mch_pkg::in_beat_t pack_axes(logic [15:0] ax, logic [15:0] ay,
                                                  logic [15:0] az);
    mch_pkg::in_beat_t b;
    if (cfg_shadow[mch_pkg::REG_CHIP_LAYOUT][1:0] == mch_pkg::LAYOUT_LE_XYZ)
      b = {ax[7:0], ax[15:8], ay[7:0], ay[15:8], az[7:0], az[15:8]};
    else
      b = {ax, az, ay};
    return b;
  endfunction

  task automatic send_sample(input mch_pkg::in_beat_t b);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    heading_q.push_back(predict_heading(b));
    samples_sent++;
  endtask

  // wait until every expected beat has come back, so the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (heading_q.size() != 0);
  endtask

  task automatic program_regs();
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= reg_plan[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    for (i = 0; i < 8; i++) cfg_shadow[i] = reg_plan[i];
    cfg_shadow[mch_pkg::REG_CHIP_LAYOUT] = {14'd0, reg_plan[mch_pkg::REG_CHIP_LAYOUT][1:0]};
    settings_applied++;
  endtask

  task automatic plan_plain(input logic [1:0] layout);
    reg_plan[mch_pkg::REG_CHIP_LAYOUT] = {14'd0, layout};
    reg_plan[mch_pkg::REG_OFFSET_X]    = 16'd0;
    reg_plan[mch_pkg::REG_OFFSET_Y]    = 16'd0;
    reg_plan[mch_pkg::REG_OFFSET_Z]    = 16'd0;
    reg_plan[mch_pkg::REG_SCALE_X]     = mch_pkg::SCALE_ONE;
    reg_plan[mch_pkg::REG_SCALE_Y]     = mch_pkg::SCALE_ONE;
    reg_plan[mch_pkg::REG_SCALE_Z]     = mch_pkg::SCALE_ONE;
    reg_plan[mch_pkg::REG_DECLINATION] = 16'd0;
  endtask

  task automatic plan_random();
    int r, k;
    r = $urandom_range(0, 9);
    if (r < 4)      reg_plan[mch_pkg::REG_CHIP_LAYOUT] = {14'd0, mch_pkg::LAYOUT_BE_XZY};
    else if (r < 8) reg_plan[mch_pkg::REG_CHIP_LAYOUT] = {14'd0, mch_pkg::LAYOUT_LE_XYZ};
    else if (r < 9) reg_plan[mch_pkg::REG_CHIP_LAYOUT] = {14'd0, mch_pkg::LAYOUT_NONE};
    else            reg_plan[mch_pkg::REG_CHIP_LAYOUT] = {14'd0, LAYOUT_SPARE};
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(0, 3) == 0)
        reg_plan[mch_pkg::REG_OFFSET_X + k] = 16'($urandom);
      else
        reg_plan[mch_pkg::REG_OFFSET_X + k] = 16'($urandom_range(0, 2048) - 1024);
      if ($urandom_range(0, 3) == 0)
        reg_plan[mch_pkg::REG_SCALE_X + k] = 16'($urandom);
      else
        reg_plan[mch_pkg::REG_SCALE_X + k] = 16'($urandom_range(2048, 8192));
    end
    if ($urandom_range(0, 7) == 0)
      reg_plan[mch_pkg::REG_DECLINATION] = 16'($urandom);
    else
      reg_plan[mch_pkg::REG_DECLINATION] = 16'($urandom_range(0, 46080) - 23040);
  endtask

  task automatic send_random_sample();
    logic [15:0] ax, ay, az;
    int k;
    ax = 16'($urandom);
    ay = 16'($urandom);
    az = 16'($urandom);
    k = $urandom_range(0, 9);
    if (k == 0) begin
      case ($urandom_range(0, 2))
        0: ax = mch_pkg::OVF_MARK;
        1: ay = mch_pkg::OVF_MARK;
        default: az = mch_pkg::OVF_MARK;
      endcase
    end else if (k == 1) begin
      // lands at or next to the offsets, down to the zero vector
      ax = cfg_shadow[mch_pkg::REG_OFFSET_X] + 16'($urandom_range(0, 4) - 2);
      ay = cfg_shadow[mch_pkg::REG_OFFSET_Y] + 16'($urandom_range(0, 4) - 2);
    end
    send_sample(pack_axes(ax, ay, az));
  endtask

  // reset settings: no sensor, so every beat is rejected with a zero field
  task automatic test_power_on();
    int i;
    for (i = 0; i < 2; i++) send_sample({16'($urandom), $urandom});
    drain();
  endtask

  task automatic test_layout_decode();
    plan_plain(mch_pkg::LAYOUT_BE_XZY);
    program_regs();
    send_sample(pack_axes(16'h7FFF, 16'h0000, 16'h0000));
    send_sample(pack_axes(16'h8000, 16'h7FFF, 16'h8000));
    send_sample(pack_axes(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pack_axes(mch_pkg::OVF_MARK, 16'h0123, 16'h0456));
    send_sample(pack_axes(16'h0123, mch_pkg::OVF_MARK, 16'h0456));
    send_sample(pack_axes(16'h0123, 16'h0456, mch_pkg::OVF_MARK));
    send_sample(pack_axes(16'hF001, 16'h0FFF, 16'hEFFF));
    drain();
    plan_plain(mch_pkg::LAYOUT_LE_XYZ);
    program_regs();
    send_sample(pack_axes(mch_pkg::OVF_MARK, mch_pkg::OVF_MARK, mch_pkg::OVF_MARK));
    send_sample(pack_axes(16'h8000, 16'h8000, 16'h7FFF));
    send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_axes(16'h1234, 16'hABCD, 16'h5A5A));
    drain();
    plan_plain(LAYOUT_SPARE);
    program_regs();
    send_sample({48{1'b1}});
    drain();
    plan_plain(mch_pkg::LAYOUT_NONE);
    program_regs();
    send_sample({24{2'b10}});
    drain();
  endtask

  task automatic test_calibration_edges();
    plan_plain(mch_pkg::LAYOUT_LE_XYZ);
    reg_plan[mch_pkg::REG_OFFSET_X]    = 16'h7FFF;
    reg_plan[mch_pkg::REG_OFFSET_Y]    = 16'h8000;
    reg_plan[mch_pkg::REG_OFFSET_Z]    = 16'h7FFF;
    reg_plan[mch_pkg::REG_SCALE_X]     = 16'hFFFF;
    reg_plan[mch_pkg::REG_SCALE_Y]     = 16'hFFFF;
    reg_plan[mch_pkg::REG_SCALE_Z]     = 16'h0000;
    reg_plan[mch_pkg::REG_DECLINATION] = 16'h8000;
    program_regs();
    // saturation both ways, then values that cancel the offsets or miss them by one
    send_sample(pack_axes(16'h8000, 16'h7FFF, 16'h8000));
    send_sample(pack_axes(16'h7FFF, 16'h8000, 16'h1234));
    send_sample(pack_axes(16'h7FFE, 16'h8001, 16'h0000));
    drain();
    plan_plain(mch_pkg::LAYOUT_BE_XZY);
    reg_plan[mch_pkg::REG_SCALE_X]     = 16'h0000;
    reg_plan[mch_pkg::REG_SCALE_Y]     = 16'h0000;
    reg_plan[mch_pkg::REG_DECLINATION] = 16'h7FFF;
    program_regs();
    send_sample(pack_axes(16'h4000, 16'hC000, 16'h0001));
    drain();
    reg_plan[mch_pkg::REG_DECLINATION] = 16'(-23040);
    program_regs();
    send_sample(pack_axes(16'h0100, 16'h0200, 16'h0300));
    drain();
    reg_plan[mch_pkg::REG_SCALE_X]     = mch_pkg::SCALE_ONE;
    reg_plan[mch_pkg::REG_SCALE_Y]     = mch_pkg::SCALE_ONE;
    reg_plan[mch_pkg::REG_DECLINATION] = 16'd23040;
    program_regs();
    send_sample(pack_axes(16'hFF00, 16'h0000, 16'h0300));
    drain();
  endtask

  task automatic test_random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        drain();
        plan_random();
        program_regs();
      end
      send_random_sample();
    end
    drain();
  endtask

  // receiver stops for a long stretch; the block fills and holds off its input
  task automatic test_output_stall();
    int i;
    plan_random();
    reg_plan[mch_pkg::REG_CHIP_LAYOUT] = {14'd0, mch_pkg::LAYOUT_BE_XZY};
    program_regs();
    hold_left = 300;
    for (i = 0; i < 12; i++) send_random_sample();
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    mch_pkg::out_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (heading_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        err_count++;
      end else begin
        exp_beat = heading_q.pop_front();
        if (exp_beat.sample_rejected) rejects_seen++;
        if (out_data.heading !== exp_beat.heading) begin
          $error("heading: expected %0d, got %0d", exp_beat.heading, out_data.heading);
          err_count++;
        end
        if (out_data.field_x !== exp_beat.field_x) begin
          $error("field_x: expected %0d, got %0d", exp_beat.field_x, out_data.field_x);
          err_count++;
        end
        if (out_data.field_y !== exp_beat.field_y) begin
          $error("field_y: expected %0d, got %0d", exp_beat.field_y, out_data.field_y);
          err_count++;
        end
        if (out_data.field_z !== exp_beat.field_z) begin
          $error("field_z: expected %0d, got %0d", exp_beat.field_z, out_data.field_z);
          err_count++;
        end
        if (out_data.sample_rejected !== exp_beat.sample_rejected) begin
          $error("sample_rejected: expected %0d, got %0d",
                 exp_beat.sample_rejected, out_data.sample_rejected);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    plan_plain(mch_pkg::LAYOUT_NONE);
    for (int i = 0; i < 8; i++) cfg_shadow[i] = reg_plan[i];
    fld_x = '0;
    fld_y = '0;
    fld_z = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on();
    test_layout_decode();
    test_calibration_edges();
    tx_idle_pct = 31;
    rx_idle_pct = 60;
    test_random_traffic(320);
    tx_idle_pct = 60;
    rx_idle_pct = 31;
    test_random_traffic(320);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_random_traffic(310);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d sensor beats under %0d register settings, %0d of them rejected",
             samples_sent, settings_applied, rejects_seen);
    $display("layouts, overflow marker, saturation, zero vector, declination wrap, stalls");
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
design/mch_pkg.sv
design/mch_calib.sv
design/mch_cordic.sv
design/magnetometer_compass_heading.sv
dv/magnetometer_compass_heading_tb.sv
